FILE: src/gtm_pkg.sv
// ============================================================================
// Goertzel tone magnitude package
// Shared widths, register codes, reset values, types and state encodings.
// ============================================================================
package gtm_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int COEF_W      = 16;
  localparam int LEN_W       = 11;
  localparam int ACC_W       = 40;
  localparam int MAG_W       = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  // Product of a coefficient and an accumulator value.
  localparam int PROD_W = COEF_W + ACC_W;

  localparam int DEFAULT_MAX_BLOCK = 1024;
  localparam int QUEUE_DEPTH       = 2;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TWO_COS_W    = 2'd0,
    REG_SIN_W        = 2'd1,
    REG_BLOCK_LENGTH = 2'd2
  } cfg_reg_t;

  localparam coef_t             TWO_COS_W_RESET    = 16'sd31652;
  localparam coef_t             SIN_W_RESET        = 16'sd8481;
  localparam logic [LEN_W-1:0]  BLOCK_LENGTH_RESET = 11'd960;

  localparam acc_t ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam acc_t ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // One finished block as handed from the front end to the back end.
  typedef struct packed {
    acc_t  delay_one;
    acc_t  delay_two;
    coef_t two_cos_w;
    coef_t sin_w;
  } block_t;

  typedef enum logic {
    FRONT_IDLE,
    FRONT_ACCUM
  } front_state_t;

  typedef enum logic [3:0] {
    BACK_IDLE,
    BACK_MUL_RE,
    BACK_MUL_IM,
    BACK_ABS,
    BACK_SQ_RE,
    BACK_SQ_IM,
    BACK_SQRT,
    BACK_DIV,
    BACK_OUT
  } back_state_t;

endpackage

FILE: src/goertzel_tone_magnitude.sv
// ============================================================================
// Goertzel tone magnitude meter
// Measures the strength of one configured tone over blocks of audio samples.
// ============================================================================
//
//   Channel     Direction  Handshake                    Payload
//   sample      in         sample_valid / sample_ready  sample, signed Q1.15
//   magnitude   out        magnitude_valid / _ready     magnitude, unsigned Q1.15
//   config      in         cfg_write (no wait)          cfg_index, cfg_data
//
// The front end takes a new sample request only after it has closed the last:
// the accept edge registers the coefficient product and the accumulate state
// closes the recurrence, waiting for the queue when it ends a block. The back
// end works on one block at a time, mostly in its 32-step square root and divide.
// A two-entry block queue lets the front end keep sampling while the back end
// works or its output stalls; the output register holds a result until taken.
// Reset is synchronous and active high and needs no clearing pass.
//
module goertzel_tone_magnitude
  import gtm_pkg::*;
#(
  parameter int MAX_BLOCK = DEFAULT_MAX_BLOCK
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     sample_valid,
  output logic                     sample_ready,
  input  logic signed [SAMPLE_W-1:0] sample,
  output logic                     magnitude_valid,
  input  logic                     magnitude_ready,
  output logic [MAG_W-1:0]         magnitude,
  input  logic                     cfg_write,
  input  logic [CFG_INDEX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data
);

  localparam int CNT_W    = $clog2(MAX_BLOCK + 1);
  localparam int QUEUE_W  = $bits(block_t) + CNT_W;

  // Configuration registers. A write applies to the following samples, also
  // those of the block under way.
  coef_t             two_cos_w;
  coef_t             sin_w;
  logic [LEN_W-1:0]  block_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      two_cos_w    <= TWO_COS_W_RESET;
      sin_w        <= SIN_W_RESET;
      block_length <= BLOCK_LENGTH_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_TWO_COS_W:    two_cos_w    <= coef_t'(cfg_data);
        REG_SIN_W:        sin_w        <= coef_t'(cfg_data);
        REG_BLOCK_LENGTH: block_length <= cfg_data[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front end to queue.
  logic             push_valid, push_ready;
  block_t           push_block;
  logic [CNT_W-1:0] push_count;

  // Queue to back end.
  logic             pop_valid, pop_ready;
  logic [QUEUE_W-1:0] pop_data;
  block_t           pop_block;
  logic [CNT_W-1:0] pop_count;

  gtm_front #(
    .MAX_BLOCK(MAX_BLOCK)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .two_cos_w    (two_cos_w),
    .sin_w        (sin_w),
    .block_length (block_length),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_block   (push_block),
    .push_count   (push_count)
  );

  gtm_fifo #(
    .WIDTH(QUEUE_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_block, push_count}),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  assign pop_block = pop_data[QUEUE_W-1:CNT_W];
  assign pop_count = pop_data[CNT_W-1:0];

  gtm_back #(
    .MAX_BLOCK(MAX_BLOCK)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .pop_valid       (pop_valid),
    .pop_ready       (pop_ready),
    .pop_block       (pop_block),
    .pop_count       (pop_count),
    .magnitude_valid (magnitude_valid),
    .magnitude_ready (magnitude_ready),
    .magnitude       (magnitude)
  );

  // The front end never takes a sample while it is handing off a block.
  assert property (@(posedge clk) disable iff (rst) push_valid |-> !sample_ready)
    else $error("sample request taken while a block hand-off is pending");

  // Leaving reset, the front end is ready for the first sample.
  assert property (@(posedge clk) $fell(rst) |-> sample_ready)
    else $error("front end not ready after reset");

  // The back end works on one block at a time.
  assert property (@(posedge clk) disable iff (rst)
                   (pop_valid && pop_ready) |=> !pop_ready)
    else $error("back end took a second block while busy");

endmodule

FILE: src/gtm_front.sv
// ============================================================================
// Goertzel front end
// Takes samples, runs the recurrence and hands each finished block to the queue.
// ============================================================================
module gtm_front
  import gtm_pkg::*;
#(
  parameter int MAX_BLOCK = DEFAULT_MAX_BLOCK
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 sample_valid,
  output logic                                 sample_ready,
  input  logic signed [SAMPLE_W-1:0]           sample,
  input  coef_t                                two_cos_w,
  input  coef_t                                sin_w,
  input  logic [LEN_W-1:0]                     block_length,
  output logic                                 push_valid,
  input  logic                                 push_ready,
  output block_t                               push_block,
  output logic [$clog2(MAX_BLOCK+1)-1:0]       push_count
);

  localparam int CNT_W  = $clog2(MAX_BLOCK + 1);
  localparam int FB_W   = PROD_W - 14;
  localparam int SUM_W  = FB_W + 2;
  localparam logic signed [PROD_W-1:0] HALF_Q14 = PROD_W'(1) << 13;

  front_state_t              state, state_next;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic signed [PROD_W-1:0]  prod;
  acc_t                      delay_one, delay_two;
  logic [CNT_W-1:0]          count;

  logic signed [PROD_W-1:0]  prod_next, prod_round;
  logic signed [FB_W-1:0]    feedback;
  logic signed [SUM_W-1:0]   sum;
  acc_t                      q0;
  logic [CNT_W-1:0]          len_eff, taken;
  logic                      block_done, advance;

  assign prod_next  = PROD_W'(two_cos_w) * PROD_W'(delay_one);
  assign prod_round = prod + HALF_Q14;
  assign feedback   = FB_W'(prod_round >>> 14);
  assign sum        = SUM_W'(sample_r) + SUM_W'(feedback) - SUM_W'(delay_two);

  always_comb begin
    if (sum[SUM_W-1:ACC_W-1] == '0 || sum[SUM_W-1:ACC_W-1] == '1) begin
      q0 = sum[ACC_W-1:0];
    end else if (sum[SUM_W-1]) begin
      q0 = ACC_MIN;
    end else begin
      q0 = ACC_MAX;
    end
  end

  always_comb begin
    if (block_length == '0) begin
      len_eff = CNT_W'(1);
    end else if (32'(block_length) > MAX_BLOCK) begin
      len_eff = CNT_W'(MAX_BLOCK);
    end else begin
      len_eff = CNT_W'(block_length);
    end
  end

  assign taken      = count + CNT_W'(1);
  assign block_done = (taken >= len_eff);

  assign push_block = '{delay_one: q0, delay_two: delay_one,
                        two_cos_w: two_cos_w, sin_w: sin_w};
  assign push_count = taken;

  always_comb begin
    state_next   = state;
    sample_ready = 1'b0;
    push_valid   = 1'b0;
    advance      = 1'b0;
    unique case (state)
      FRONT_IDLE: begin
        sample_ready = 1'b1;
        if (sample_valid) begin
          state_next = FRONT_ACCUM;
        end
      end
      FRONT_ACCUM: begin
        if (block_done) begin
          push_valid = 1'b1;
          if (push_ready) begin
            advance    = 1'b1;
            state_next = FRONT_IDLE;
          end
        end else begin
          advance    = 1'b1;
          state_next = FRONT_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= FRONT_IDLE;
      delay_one <= '0;
      delay_two <= '0;
      count     <= '0;
    end else begin
      state <= state_next;
      if (advance) begin
        if (block_done) begin
          delay_one <= '0;
          delay_two <= '0;
          count     <= '0;
        end else begin
          delay_one <= q0;
          delay_two <= delay_one;
          count     <= taken;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && sample_ready) begin
      sample_r <= sample;
      prod     <= prod_next;
    end
  end

endmodule

FILE: src/gtm_fifo.sv
// ============================================================================
// Goertzel block queue
// Small first-in first-out queue between the front end and the back end.
// ============================================================================
module gtm_fifo
  import gtm_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push, pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

FILE: src/gtm_back.sv
// ============================================================================
// Goertzel back end
// Turns one finished block into a magnitude: products, square root, divide.
// ============================================================================
module gtm_back
  import gtm_pkg::*;
#(
  parameter int MAX_BLOCK = DEFAULT_MAX_BLOCK
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           pop_valid,
  output logic                           pop_ready,
  input  block_t                         pop_block,
  input  logic [$clog2(MAX_BLOCK+1)-1:0] pop_count,
  output logic                           magnitude_valid,
  input  logic                           magnitude_ready,
  output logic [MAG_W-1:0]               magnitude
);

  localparam int CNT_W  = $clog2(MAX_BLOCK + 1);
  localparam int RS_W   = PROD_W - 15;
  localparam int RE_W   = RS_W + 1;
  localparam int PART_W = 30;
  localparam int SQ_W   = 2 * PART_W;
  localparam int RAD_W  = 64;
  localparam int ROOT_W = 32;
  localparam int STEP_W = $clog2(ROOT_W);
  localparam logic signed [PROD_W-1:0] HALF_Q15 = PROD_W'(1) << 14;

  back_state_t              state, state_next;
  block_t                   blk;
  logic [CNT_W-1:0]         n;
  logic signed [PROD_W-1:0] prod;
  logic signed [RE_W-1:0]   re;
  logic [PART_W-1:0]        ar_part, ai_part;
  logic [SQ_W-1:0]          sq;
  logic [RAD_W-1:0]         rad, root, bitmask;
  logic [STEP_W-1:0]        step;
  logic [ROOT_W-1:0]        quo;
  logic [CNT_W-1:0]         rem;
  logic [MAG_W-1:0]         result;

  coef_t                    mul_coef;
  logic signed [PROD_W-1:0] prod_next, prod_round;
  logic signed [RS_W-1:0]   rounded;
  logic [RE_W-1:0]          ar;
  logic [RS_W-1:0]          ai;
  logic                     big;
  logic [PART_W-1:0]        sq_op;
  logic [SQ_W-1:0]          sq_prod;
  logic [RAD_W-1:0]         trial, root_next;
  logic                     root_take;
  logic [CNT_W:0]           div_trial;
  logic                     div_take;
  logic [ROOT_W-1:0]        quo_next;
  logic                     load_out, last_step;

  // One shared coefficient multiplier for the real and imaginary products.
  assign mul_coef   = (state == BACK_MUL_RE) ? blk.two_cos_w : blk.sin_w;
  assign prod_next  = PROD_W'(blk.delay_two) * PROD_W'(mul_coef);
  assign prod_round = prod + HALF_Q15;
  assign rounded    = RS_W'(prod_round >>> 15);

  assign ar  = re[RE_W-1] ? RE_W'(-re) : RE_W'(re);
  assign ai  = rounded[RS_W-1] ? RS_W'(-rounded) : RS_W'(rounded);
  assign big = (|ar[RE_W-1:PART_W]) || (|ai[RS_W-1:PART_W]);

  // One shared squarer.
  assign sq_op   = (state == BACK_SQ_RE) ? ar_part : ai_part;
  assign sq_prod = SQ_W'(sq_op) * SQ_W'(sq_op);

  // Square root, one result bit per step.
  assign trial     = root + bitmask;
  assign root_take = (rad >= trial);
  assign root_next = root_take ? ((root >> 1) + bitmask) : (root >> 1);

  // Restoring divide, one quotient bit per step.
  assign div_trial = {rem, quo[ROOT_W-1]};
  assign div_take  = (div_trial >= {1'b0, n});
  assign quo_next  = {quo[ROOT_W-2:0], div_take};

  assign last_step = (step == STEP_W'(ROOT_W - 1));

  always_comb begin
    state_next = state;
    pop_ready  = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      BACK_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          state_next = BACK_MUL_RE;
        end
      end
      BACK_MUL_RE: state_next = BACK_MUL_IM;
      BACK_MUL_IM: state_next = BACK_ABS;
      BACK_ABS:    state_next = big ? BACK_OUT : BACK_SQ_RE;
      BACK_SQ_RE:  state_next = BACK_SQ_IM;
      BACK_SQ_IM:  state_next = BACK_SQRT;
      BACK_SQRT: begin
        if (last_step) begin
          state_next = BACK_DIV;
        end
      end
      BACK_DIV: begin
        if (last_step) begin
          state_next = BACK_OUT;
        end
      end
      BACK_OUT: begin
        if (!magnitude_valid || magnitude_ready) begin
          load_out   = 1'b1;
          state_next = BACK_IDLE;
        end
      end
      default: state_next = BACK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= BACK_IDLE;
      magnitude_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        magnitude_valid <= 1'b1;
      end else if (magnitude_ready) begin
        magnitude_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      magnitude <= result;
    end
    unique case (state)
      BACK_IDLE: begin
        blk <= pop_block;
        n   <= pop_count;
      end
      BACK_MUL_RE: prod <= prod_next;
      BACK_MUL_IM: begin
        re   <= RE_W'(blk.delay_one) - RE_W'(rounded);
        prod <= prod_next;
      end
      BACK_ABS: begin
        ar_part <= ar[PART_W-1:0];
        ai_part <= ai[PART_W-1:0];
        result  <= '1;
      end
      BACK_SQ_RE: sq <= sq_prod;
      BACK_SQ_IM: begin
        // The sum of the two squares can carry past the squarer width.
        rad     <= (RAD_W'(sq) + RAD_W'(sq_prod)) << 2;
        root    <= '0;
        bitmask <= RAD_W'(1) << (RAD_W - 2);
        step    <= '0;
      end
      BACK_SQRT: begin
        if (root_take) begin
          rad <= rad - trial;
        end
        root    <= root_next;
        bitmask <= bitmask >> 2;
        step    <= step + STEP_W'(1);
        if (last_step) begin
          quo <= root_next[ROOT_W-1:0];
          rem <= '0;
        end
      end
      BACK_DIV: begin
        rem  <= div_take ? CNT_W'(div_trial - {1'b0, n}) : div_trial[CNT_W-1:0];
        quo  <= quo_next;
        step <= step + STEP_W'(1);
        if (last_step) begin
          result <= (|quo_next[ROOT_W-1:MAG_W]) ? '1 : quo_next[MAG_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: tb/sv/tb_goertzel_tone_magnitude.sv
`timescale 1ns / 1ps
// ============================================================================
// Goertzel tone magnitude meter testbench
// Drives audio samples through the meter under a series of coefficient and
// block length settings. A scoreboard runs its own Goertzel predictor on
// every accepted sample and compares each magnitude result against it.
// ============================================================================
module tb_goertzel_tone_magnitude;
  import gtm_pkg::*;

  localparam int CLK_PERIOD      = 20;
  localparam int RESET_CYCLES    = 7;
  // Long enough to cover a sample still in flight in the front end or the
  // back end when the results run dry.
  localparam int SETTLE_CYCLES   = 100;
  localparam int QUIET_LIMIT     = 4000;
  localparam int NUM_PHASES      = 16;
  localparam int PHASE_ITEMS     = 45;
  localparam int LONG_ITEMS      = 1024;
  localparam int HOLD_OFF_CYCLES = 600;

  // Index 3 decodes to no register; writes there must be ignored.
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

  localparam coef_t            COEF_MAX  = 16'sh7FFF;
  localparam coef_t            COEF_MIN  = 16'sh8000;
  localparam logic [MAG_W-1:0] MAG_FULL  = '1;
  localparam longint           BIG_LIMIT = 64'sd1073741824;

  // --------------------------------------------------------------------------
  // Scoreboard: keeps a private copy of the coefficients, the block length and
  // the two Goertzel delays, and queues the magnitude each finished block owes.
  // --------------------------------------------------------------------------
  class tone_magnitude_scoreboard;
    coef_t             two_cos_w;
    coef_t             sin_w;
    logic [LEN_W-1:0]  block_length;
    longint            delay_one;
    longint            delay_two;
    int                sample_count;
    logic [MAG_W-1:0]  expected_magnitudes[$];
    int                errors;
    int                samples_seen;
    int                magnitudes_checked;
    int                full_scale_seen;

    function new();
      two_cos_w          = TWO_COS_W_RESET;
      sin_w              = SIN_W_RESET;
      block_length       = BLOCK_LENGTH_RESET;
      delay_one          = 0;
      delay_two          = 0;
      sample_count       = 0;
      errors             = 0;
      samples_seen       = 0;
      magnitudes_checked = 0;
      full_scale_seen    = 0;
    endfunction

    // Divide by 2^sh, rounding half up (add half, then floor).
    function longint round_shift(longint v, int sh);
      return (v + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    // A write takes effect at once, also for the block under way.
    function void set_register(logic [CFG_INDEX_W-1:0] index,
                               logic [CFG_DATA_W-1:0] data);
      case (index)
        REG_TWO_COS_W:    two_cos_w = data;
        REG_SIN_W:        sin_w = data;
        REG_BLOCK_LENGTH: block_length = data[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_sample(logic signed [SAMPLE_W-1:0] value);
      longint            coef_c;
      longint            coef_s;
      longint            next_q;
      longint            re;
      longint            im;
      longint unsigned   abs_re;
      longint unsigned   abs_im;
      longint unsigned   energy;
      longint unsigned   root;
      longint unsigned   bit_pos;
      longint unsigned   quotient;
      int                len;
      int                taken;
      coef_c = two_cos_w;
      coef_s = sin_w;
      len    = block_length;
      if (len == 0) len = 1;
      if (len > DEFAULT_MAX_BLOCK) len = DEFAULT_MAX_BLOCK;
      samples_seen++;

      next_q = longint'(value) + round_shift(coef_c * delay_one, 14) - delay_two;
      if (next_q > longint'(ACC_MAX)) next_q = longint'(ACC_MAX);
      if (next_q < longint'(ACC_MIN)) next_q = longint'(ACC_MIN);
      delay_two = delay_one;
      delay_one = next_q;

      // A block ends once the count reaches the length, which also covers a
      // length lowered below the samples already taken.
      taken = sample_count + 1;
      if (taken < len) begin
        sample_count = taken;
        return;
      end

      // cos(w) is two_cos_w read as Q1.15, hence the shift by 15.
      re     = delay_one - round_shift(delay_two * coef_c, 15);
      im     = round_shift(delay_two * coef_s, 15);
      abs_re = (re < 0) ? -re : re;
      abs_im = (im < 0) ? -im : im;
      if (abs_re >= BIG_LIMIT || abs_im >= BIG_LIMIT) begin
        quotient = MAG_FULL;
      end else begin
        energy  = 4 * (abs_re * abs_re + abs_im * abs_im);
        root    = 0;
        bit_pos = 64'd1 << 62;
        while (bit_pos > energy) bit_pos >>= 2;
        while (bit_pos != 0) begin
          if (energy >= root + bit_pos) begin
            energy = energy - (root + bit_pos);
            root   = (root >> 1) + bit_pos;
          end else begin
            root = root >> 1;
          end
          bit_pos >>= 2;
        end
        quotient = root / longint'(taken);
        if (quotient > MAG_FULL) quotient = MAG_FULL;
      end
      expected_magnitudes.push_back(MAG_W'(quotient));
      delay_one    = 0;
      delay_two    = 0;
      sample_count = 0;
    endfunction

    function void check_magnitude(logic [MAG_W-1:0] actual);
      logic [MAG_W-1:0] expected;
      if (expected_magnitudes.size() == 0) begin
        errors++;
        $error("magnitude: no result expected, actual %0d", actual);
        return;
      end
      expected = expected_magnitudes.pop_front();
      magnitudes_checked++;
      if (expected == MAG_FULL) full_scale_seen++;
      if (actual !== expected) begin
        errors++;
        $error("magnitude: expected %0d, actual %0d", expected, actual);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals. Every input of the meter starts at a known value.
  // --------------------------------------------------------------------------
  logic                       clk;
  logic                       rst = 1'b1;
  logic                       sample_valid = 1'b0;
  logic                       sample_ready;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic                       magnitude_valid;
  logic                       magnitude_ready = 1'b0;
  logic [MAG_W-1:0]           magnitude;
  logic                       cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;

  // Idle mix for the current phase, in percent of cycles.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  // A long receiver hold-off, counted down by the receiver process itself.
  int hold_cycles    = 0;
  int quiet_cycles   = 0;
  int settings_applied = 0;

  tone_magnitude_scoreboard sb;

  goertzel_tone_magnitude u_dut (
    .clk             (clk),
    .rst             (rst),
    .sample_valid    (sample_valid),
    .sample_ready    (sample_ready),
    .sample          (sample),
    .magnitude_valid (magnitude_valid),
    .magnitude_ready (magnitude_ready),
    .magnitude       (magnitude),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // The receiver stalls at random per the phase mix. When a hold-off is
  // requested it keeps ready low for that many cycles, so the block queue
  // fills up and the meter has to push back on its sample input.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        magnitude_ready <= 1'b0;
        hold_cycles = hold_cycles - 1;
      end else begin
        magnitude_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Every magnitude request taken at an edge is checked against the oldest
  // prediction. Signals are read before the edge's updates land.
  always @(posedge clk) begin
    if (!rst && magnitude_valid && magnitude_ready) sb.check_magnitude(magnitude);
  end

  // Watchdog: the run is declared hung after too many cycles with no request
  // moving on either channel.
  always @(posedge clk) begin
    if (rst || (sample_valid && sample_ready) || (magnitude_valid && magnitude_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_goertzel_tone_magnitude: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one sample request, after a random gap per the sender's idle mix,
  // and holds it until the meter takes it. Valid stays high on return so the
  // next request can follow back to back.
  task automatic send_sample(logic [SAMPLE_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= value;
    do @(posedge clk); while (!sample_ready);
    sb.note_sample(value);
  endtask

  // Stops offering samples and waits until every predicted magnitude has come
  // back, then lets any sample still inside the front end settle.
  task automatic drain_results();
    sample_valid <= 1'b0;
    while (sb.expected_magnitudes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes both coefficients, the unused index and the block length on
  // consecutive edges. Only called while the meter is idle.
  task automatic apply_settings(coef_t two_cos, coef_t sine,
                                logic [CFG_DATA_W-1:0] length_word);
    logic [CFG_INDEX_W-1:0] order[4];
    logic [CFG_DATA_W-1:0]  words[4];
    order = '{REG_TWO_COS_W, REG_SIN_W, REG_SPARE, REG_BLOCK_LENGTH};
    words = '{two_cos, sine, CFG_DATA_W'($urandom), length_word};
    for (int i = 0; i < 4; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= order[i];
      cfg_data  <= words[i];
      @(posedge clk);
      sb.set_register(cfg_index, cfg_data);
    end
    cfg_write <= 1'b0;
    settings_applied++;
  endtask

  // Coefficients lean toward the extremes and zero.
  function automatic coef_t pick_coef();
    case ($urandom_range(0, 5))
      0:       return COEF_MIN;
      1:       return COEF_MAX;
      2:       return '0;
      default: return coef_t'($urandom);
    endcase
  endfunction

  // Mostly full-range noise, with extremes, zero and quiet samples mixed in.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return COEF_MAX;
      1:       return COEF_MIN;
      2:       return '0;
      3:       return SAMPLE_W'($urandom_range(0, 512) - 256);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  initial begin
    logic [LEN_W-1:0]      len;
    logic [CFG_DATA_W-1:0] length_word;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed: coefficient -2.0 with sin(w) at its negative extreme, blocks
    // of two. The first block drives the magnitude past full scale.
    apply_settings(COEF_MIN, COEF_MIN, CFG_DATA_W'(2));
    send_sample(COEF_MIN);
    send_sample(COEF_MAX);
    send_sample(COEF_MAX);
    send_sample(COEF_MIN);
    send_sample(16'h5555);
    send_sample(16'hAAAA);
    drain_results();

    // Directed: a block length of zero acts as one, so every sample yields
    // a magnitude. Both coefficients sit at their positive extreme.
    apply_settings(COEF_MAX, COEF_MAX, '0);
    send_sample(COEF_MAX);
    send_sample(COEF_MIN);
    send_sample('0);
    send_sample(16'h0001);
    send_sample(16'hFFFF);
    drain_results();

    // Directed: the length drops below the samples already taken in a
    // block. The block then ends on the next sample and divides by six.
    apply_settings(TWO_COS_W_RESET, SIN_W_RESET, CFG_DATA_W'(8));
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h1234);
    send_sample(16'hEDCB);
    send_sample(16'h4000);
    drain_results();
    apply_settings(TWO_COS_W_RESET, SIN_W_RESET, CFG_DATA_W'(3));
    send_sample(16'h0001);
    drain_results();

    // Random phases. Each picks new coefficients and a short block, and cycles
    // through the four idle mixes. Phases often end mid-block, so the next
    // setting changes the length of a block already under way. Phase seven
    // uses the longest legal length and leaves its block open for the next
    // phase to cut short.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       len = 1;
        1:       len = 0;
        4:       len = 2;
        7:       len = DEFAULT_MAX_BLOCK;
        default: len = $urandom_range(2, 48);
      endcase
      // Bits above the block length field are don't-care in the write.
      length_word = CFG_DATA_W'($urandom);
      length_word[LEN_W-1:0] = len;
      apply_settings(pick_coef(), pick_coef(), length_word);
      case (p % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 54; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 54; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // With blocks of two and no idling, a long hold-off on the receiver
        // backs the meter up while samples keep arriving.
        if (p == 4 && i == 20) hold_cycles = HOLD_OFF_CYCLES;
        // Halfway through one phase the sender goes quiet until every
        // outstanding magnitude has come back.
        if (p == 6 && i == PHASE_ITEMS / 2) drain_results();
        send_sample(pick_sample());
      end
      drain_results();
    end

    // One full block at the maximum length, requested through an oversized
    // setting. A Nyquist tone at coefficient -2.0 grows the delays without
    // bound, so the imaginary part saturates the magnitude.
    length_word = CFG_DATA_W'($urandom);
    length_word[LEN_W-1:0] = '1;
    apply_settings(COEF_MIN, COEF_MAX, length_word);
    send_idle_pct  = 30;
    recv_stall_pct = 30;
    for (int i = 0; i < LONG_ITEMS; i++) begin
      if (i % 2 == 0) send_sample(COEF_MAX - $urandom_range(0, 63));
      else            send_sample(COEF_MIN + $urandom_range(0, 63));
    end
    drain_results();

    $display("Summary: %0d samples under %0d register settings, %0d magnitudes checked",
             sb.samples_seen, settings_applied, sb.magnitudes_checked);
    $display("Summary: %0d at full scale; idle mixes, one long hold-off, one mid-run drain",
             sb.full_scale_seen);
    if (sb.errors == 0 && sb.expected_magnitudes.size() == 0) begin
      $display("tb_goertzel_tone_magnitude: clean");
    end else begin
      $display("tb_goertzel_tone_magnitude: errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/gtm_pkg.sv
src/gtm_front.sv
src/gtm_fifo.sv
src/gtm_back.sv
src/goertzel_tone_magnitude.sv
tb/sv/tb_goertzel_tone_magnitude.sv
